[rtl/fbr_pkg.sv]
// Shared types and constants for the seven-tap baseline removal block.
// Holds the transfer payload structs, tap weights and result queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package fbr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int TAPS        = 7;
  localparam int HALF        = 3;
  localparam int MAX_RES     = 4;
  localparam int ACC_BITS    = SAMPLE_BITS + 8;
  localparam int SHIFT       = 7;
  localparam int CNT_BITS    = 3;
  localparam int NRES_BITS   = 3;

  // Result queue: room for two full bursts in flight beyond the stall mark
  localparam int QDEPTH      = 16;
  localparam int QADDR_BITS  = 4;
  localparam int QLVL_BITS   = QADDR_BITS + 1;
  localparam int QSTALL_MARK = QDEPTH - 2 * MAX_RES;

  localparam int WEIGHTS [TAPS] = '{2, 12, 30, 40, 30, 12, 2};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;
  } item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] corrected;
    logic                       is_final;
  } result_t;

endpackage

[rtl/fbr_queue.sv]
// Result queue for the baseline removal block: takes up to four results a
// cycle and hands them out one per transfer. Depends on fbr_pkg.
`timescale 1ns / 1ps

module fbr_queue
  import fbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [NRES_BITS-1:0]  wr_count,
  input  result_t               wr_data [MAX_RES],
  output logic [QLVL_BITS-1:0]  level,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  result_t               mem [QDEPTH];
  logic [QADDR_BITS-1:0] wr_ptr;
  logic [QADDR_BITS-1:0] rd_ptr;
  logic                  pop;

  assign result_valid = (level != '0);
  assign pop          = result_valid && !result_stall;
  assign result       = mem[rd_ptr];

  // Store the burst at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (NRES_BITS'(i) < wr_count) begin
        mem[wr_ptr + QADDR_BITS'(i)] <= wr_data[i];
      end
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QADDR_BITS'(wr_count);
      if (pop) begin
        rd_ptr <= rd_ptr + QADDR_BITS'(1);
      end
      level <= level + QLVL_BITS'(wr_count) - QLVL_BITS'(pop);
    end
  end

endmodule

[rtl/fir_baseline_removal.sv]
// Top level of the seven-tap baseline removal block.
// Depends on fbr_pkg and fbr_queue.
`timescale 1ns / 1ps

// Accepts one signed sample per clock and returns each sample three positions
// later with a floored 2,12,30,40,30,12,2 / 128 baseline subtracted; the first
// and last three samples of a record pass through raw. A sample with
// end_of_stream flushes up to four results at once, the last one flagged
// is_final. The sample window shifts at the input transfer edge; the next edge
// forms the results and writes them into a 16-entry result queue, whose head
// is offered as the result. Sustained rate is one sample per cycle; the input
// stalls only when the result queue holds more than eight results, so flush
// bursts drain at one result per cycle while result_stall is low.

module fir_baseline_removal
  import fbr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic signed [SAMPLE_BITS-1:0] win [TAPS];
  logic [CNT_BITS-1:0]           cnt;
  logic                          restart;
  logic                          stg_valid;
  logic                          stg_last;
  logic                          take;

  logic signed [ACC_BITS-1:0]    acc;
  logic signed [OUT_BITS-1:0]    baseline;
  logic signed [OUT_BITS-1:0]    center;
  logic                          has_center;
  logic [1:0]                    pend;
  logic [NRES_BITS-1:0]          nres;
  logic [NRES_BITS-1:0]          wr_count;
  logic [2:0]                    idx;
  result_t                       ent [MAX_RES];
  logic [QLVL_BITS-1:0]          level;

  assign item_stall = (level > QLVL_BITS'(QSTALL_MARK));
  assign take       = item_valid && !item_stall;

  // Shift the sample window and count samples of the current record
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = TAPS - 1; k > 0; k--) begin
        win[k] <= win[k-1];
      end
      win[0] <= item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      restart   <= 1'b0;
      stg_valid <= 1'b0;
      stg_last  <= 1'b0;
    end else begin
      stg_valid <= take;
      if (take) begin
        stg_last <= item.end_of_stream;
        restart  <= item.end_of_stream;
        if (restart) begin
          cnt <= CNT_BITS'(1);
        end else if (cnt != CNT_BITS'(TAPS)) begin
          cnt <= cnt + CNT_BITS'(1);
        end
      end
    end
  end

  // Weighted baseline, floored by arithmetic shift, subtracted from the center
  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + ACC_BITS'(win[k]) * ACC_BITS'(WEIGHTS[k]);
    end
    baseline = acc[SHIFT +: OUT_BITS];
    if (cnt == CNT_BITS'(TAPS)) begin
      center = OUT_BITS'(win[HALF]) - baseline;
    end else begin
      center = OUT_BITS'(win[HALF]);
    end
  end

  // Form the burst: delayed center first, then raw flush of pending samples
  always_comb begin
    has_center = (cnt > CNT_BITS'(HALF));
    if (!stg_last) begin
      pend = '0;
    end else if (cnt < CNT_BITS'(HALF)) begin
      pend = cnt[1:0];
    end else begin
      pend = 2'(HALF);
    end
    nres     = NRES_BITS'(has_center) + NRES_BITS'(pend);
    wr_count = stg_valid ? nres : '0;
    idx      = '0;
    for (int j = 0; j < MAX_RES; j++) begin
      idx = 3'(pend) - 3'd1 - 3'(j) + 3'(has_center);
      if (has_center && (j == 0)) begin
        ent[j].corrected = center;
      end else begin
        ent[j].corrected = OUT_BITS'(win[idx]);
      end
      ent[j].is_final = stg_last && (NRES_BITS'(j) == nres - NRES_BITS'(1));
    end
  end

  fbr_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .wr_count     (wr_count),
    .wr_data      (ent),
    .level        (level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
